// ----- design/fips_pkg.sv -----
// Shared types and constants of the filtered incremental PI speed controller.
`default_nettype none

package fips_pkg;

    // Fixed widths of the configuration registers and the drive output.
    localparam int GAIN_W   = 16;
    localparam int WEIGHT_W = 9;
    localparam int DRIVE_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_WEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN     = 3'd4;

    // Register values after reset.
    localparam logic [GAIN_W-1:0]   PROP_GAIN_RST     = 16'd768;
    localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST    = 16'd26;
    localparam logic [WEIGHT_W-1:0] FILTER_WEIGHT_RST = 9'd77;
    localparam logic [DRIVE_W-1:0]  DRIVE_MAX_RST     = 16'd2200;
    localparam logic [DRIVE_W-1:0]  DRIVE_MIN_RST     = 16'd1000;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILT_A,
        ST_FILT_B,
        ST_FILT_DIV,
        ST_ERR,
        ST_PI_P,
        ST_PI_I,
        ST_PI_SUM,
        ST_CLAMP
    } state_t;

    // Control of the shared multiply-accumulate unit.
    typedef struct packed {
        logic en;
        logic accum;
    } mac_ctrl_t;

endpackage

`default_nettype wire

// ----- design/fips_mac.sv -----
// Shared signed multiply-accumulate unit of the speed controller.
`default_nettype none

module fips_mac #(
    parameter int A_W   = 19,
    parameter int B_W   = 17,
    parameter int ACC_W = 37
) (
    input  wire logic                    clk,
    input  wire fips_pkg::mac_ctrl_t     ctrl,
    input  wire logic signed [A_W-1:0]   a,
    input  wire logic signed [B_W-1:0]   b,
    output logic signed [ACC_W-1:0]      acc
);
    import fips_pkg::*;

    localparam int P_W = A_W + B_W;

    logic signed [P_W-1:0]   prod;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    assign prod = a * b;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.en)
        begin
            if (ctrl.accum)
                acc_next = acc_reg + ACC_W'(prod);
            else
                acc_next = ACC_W'(prod);
        end
    end

    // Payload register, no reset needed: every item loads it before use.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ----- design/filtered_incremental_pi_speed.sv -----
// Top level of the filtered incremental PI speed controller for one motor.
// Usage: one input beat per control tick carries measured_speed (signed pulse
// count), target_speed (signed) and clear, on a valid/ready channel. Each
// input beat yields exactly one output beat, drive_level, the clamped drive.
// A normal beat walks a sequencer through eight states that share one signed
// multiply-accumulate unit: two products for the low-pass filter, the filter
// division, the error, two products for the incremental PI term, the bias add
// and the clamp. The result enters the output register as the sequencer
// leaves the clamp state, and in_ready returns at the same edge. A beat is
// accepted only in the idle state, never while another is in work; a clear
// beat skips the arithmetic, goes straight to the clamp state and gives zero.
// The output register parts the two sides: if the receiver stalls, the clamp
// state holds until the previous result is taken, and no result is lost.
// The configuration channel is always ready; the user must write registers
// only while the block is idle, and the block itself does not enforce this.
// Reset restores the default gains, weight and limits, zeros the filter,
// error and drive state and empties the output.
`default_nettype none

module filtered_incremental_pi_speed #(
    parameter int FRAC_BITS   = 8,
    parameter int SPEED_WIDTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Input channel.
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [SPEED_WIDTH-1:0]         measured_speed,
    input  wire logic signed [SPEED_WIDTH-1:0]         target_speed,
    input  wire logic                                  clear,
    // Output channel.
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [fips_pkg::DRIVE_W-1:0]               drive_level,
    // Configuration channel.
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [fips_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [fips_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import fips_pkg::*;

    // Fixed-point one, and a weight width that can hold it.
    localparam int ONE    = 1 << FRAC_BITS;
    localparam int WT_W   = (FRAC_BITS + 1 > WEIGHT_W) ? FRAC_BITS + 1 : WEIGHT_W;
    // The error is given two more bits than a speed, its change three.
    localparam int ERR_W  = SPEED_WIDTH + 2;
    localparam int DE_W   = SPEED_WIDTH + 3;
    // Multiplier operands: side A takes weights and errors, side B speeds and gains.
    localparam int MUL_A_W = (DE_W > WT_W + 1) ? DE_W : WT_W + 1;
    localparam int MUL_B_W = (SPEED_WIDTH > GAIN_W + 1) ? SPEED_WIDTH : GAIN_W + 1;
    localparam int ACC_W   = MUL_A_W + MUL_B_W + 1;
    localparam int SUM_W   = ACC_W + 1;

    // Configuration registers.
    logic [GAIN_W-1:0]   prop_gain_reg;
    logic [GAIN_W-1:0]   integ_gain_reg;
    logic [WEIGHT_W-1:0] filter_weight_reg;
    logic [DRIVE_W-1:0]  drive_max_reg;
    logic [DRIVE_W-1:0]  drive_min_reg;

    // Controller state.
    logic signed [SPEED_WIDTH-1:0] filtered_reg;
    logic signed [SPEED_WIDTH-1:0] filtered_next;
    logic signed [ERR_W-1:0]       last_error_reg;
    logic [DRIVE_W-1:0]            drive_accum_reg;
    logic [DRIVE_W-1:0]            drive_accum_next;

    // Captured input beat and intermediate values.
    logic signed [SPEED_WIDTH-1:0] meas_reg;
    logic signed [SPEED_WIDTH-1:0] targ_reg;
    logic                          clear_reg;
    logic signed [ERR_W-1:0]       err_reg;
    logic signed [ERR_W-1:0]       err_next;
    logic signed [DE_W-1:0]        de_reg;
    logic signed [DE_W-1:0]        de_next;
    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [SUM_W-1:0]       sum_next;

    // Output register.
    logic                          out_valid_reg;
    logic [DRIVE_W-1:0]            drive_level_reg;

    state_t state_reg;
    state_t state_next;

    logic in_fire;
    logic out_free;

    // Shared multiply-accumulate unit and its operands.
    mac_ctrl_t                   mac_ctrl;
    logic signed [MUL_A_W-1:0]   mac_a;
    logic signed [MUL_B_W-1:0]   mac_b;
    logic signed [ACC_W-1:0]     mac_acc;

    // Effective filter weight, limited to one.
    logic [WT_W-1:0] w_eff;
    logic [WT_W-1:0] w_comp;

    // Truncating division of the accumulator by one.
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [ACC_W-1:0] acc_quot;

    logic signed [SUM_W-1:0] max_ext;
    logic signed [SUM_W-1:0] min_ext;
    logic [DRIVE_W-1:0]      clamped;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign out_valid   = out_valid_reg;
    assign drive_level = drive_level_reg;

    always_comb
    begin
        if (WT_W'(filter_weight_reg) > WT_W'(ONE))
            w_eff = WT_W'(ONE);
        else
            w_eff = WT_W'(filter_weight_reg);
        w_comp = WT_W'(ONE) - w_eff;
    end

    // Adding one minus a unit to a negative numerator makes the shift round
    // toward zero instead of toward minus infinity.
    always_comb
    begin
        if (mac_acc[ACC_W-1])
            acc_rnd = mac_acc + ACC_W'(ONE - 1);
        else
            acc_rnd = mac_acc;
        acc_quot = acc_rnd >>> FRAC_BITS;
    end

    fips_mac #(
        .A_W   (MUL_A_W),
        .B_W   (MUL_B_W),
        .ACC_W (ACC_W)
    ) u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .a    (mac_a),
        .b    (mac_b),
        .acc  (mac_acc)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = clear ? ST_CLAMP : ST_FILT_A;
            end
            ST_FILT_A:   state_next = ST_FILT_B;
            ST_FILT_B:   state_next = ST_FILT_DIV;
            ST_FILT_DIV: state_next = ST_ERR;
            ST_ERR:      state_next = ST_PI_P;
            ST_PI_P:     state_next = ST_PI_I;
            ST_PI_I:     state_next = ST_PI_SUM;
            ST_PI_SUM:   state_next = ST_CLAMP;
            ST_CLAMP:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: operands and control of the shared unit.
    always_comb
    begin
        mac_ctrl = '0;
        mac_a    = '0;
        mac_b    = '0;
        case (state_reg)
            ST_FILT_A:
            begin
                // (one - w) * filtered
                mac_ctrl.en    = 1'b1;
                mac_ctrl.accum = 1'b0;
                mac_a = signed'(MUL_A_W'(w_comp));
                mac_b = MUL_B_W'(filtered_reg);
            end
            ST_FILT_B:
            begin
                // + w * measured
                mac_ctrl.en    = 1'b1;
                mac_ctrl.accum = 1'b1;
                mac_a = signed'(MUL_A_W'(w_eff));
                mac_b = MUL_B_W'(meas_reg);
            end
            ST_PI_P:
            begin
                // prop_gain * (error - last error)
                mac_ctrl.en    = 1'b1;
                mac_ctrl.accum = 1'b0;
                mac_a = MUL_A_W'(de_reg);
                mac_b = signed'(MUL_B_W'(prop_gain_reg));
            end
            ST_PI_I:
            begin
                // + integ_gain * error
                mac_ctrl.en    = 1'b1;
                mac_ctrl.accum = 1'b1;
                mac_a = MUL_A_W'(err_reg);
                mac_b = signed'(MUL_B_W'(integ_gain_reg));
            end
            default:
            begin
                mac_ctrl = '0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        // A convex mix of two speeds always fits in a speed.
        filtered_next = SPEED_WIDTH'(acc_quot);
        err_next = ERR_W'(targ_reg) - ERR_W'(filtered_reg);
        de_next  = DE_W'(err_next) - DE_W'(last_error_reg);
        sum_next = SUM_W'(acc_quot) + signed'(SUM_W'(drive_accum_reg));
        max_ext  = signed'(SUM_W'(drive_max_reg));
        min_ext  = signed'(SUM_W'(drive_min_reg));
        // The lower limit wins: it is tested first, and crossed limits give the minimum.
        if ((sum_reg < min_ext) || (drive_max_reg < drive_min_reg))
            clamped = drive_min_reg;
        else if (sum_reg > max_ext)
            clamped = drive_max_reg;
        else
            clamped = DRIVE_W'(sum_reg);
        if (clear_reg)
            drive_accum_next = '0;
        else
            drive_accum_next = clamped;
    end

    // Sequencer and controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            filtered_reg    <= '0;
            last_error_reg  <= '0;
            drive_accum_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_CLAMP) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_FILT_DIV:
                begin
                    filtered_reg <= filtered_next;
                end
                ST_PI_I:
                begin
                    last_error_reg <= err_reg;
                end
                ST_CLAMP:
                begin
                    if (out_free)
                    begin
                        drive_accum_reg <= drive_accum_next;
                        if (clear_reg)
                        begin
                            filtered_reg   <= '0;
                            last_error_reg <= '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            meas_reg  <= measured_speed;
            targ_reg  <= target_speed;
            clear_reg <= clear;
        end
        if (state_reg == ST_ERR)
        begin
            err_reg <= err_next;
            de_reg  <= de_next;
        end
        if (state_reg == ST_PI_SUM)
            sum_reg <= sum_next;
        if ((state_reg == ST_CLAMP) && out_free)
            drive_level_reg <= drive_accum_next;
    end

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= PROP_GAIN_RST;
            integ_gain_reg    <= INTEG_GAIN_RST;
            filter_weight_reg <= FILTER_WEIGHT_RST;
            drive_max_reg     <= DRIVE_MAX_RST;
            drive_min_reg     <= DRIVE_MIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PROP_GAIN:     prop_gain_reg     <= cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:    integ_gain_reg    <= cfg_data[GAIN_W-1:0];
                REG_FILTER_WEIGHT: filter_weight_reg <= cfg_data[WEIGHT_W-1:0];
                REG_DRIVE_MAX:     drive_max_reg     <= cfg_data[DRIVE_W-1:0];
                REG_DRIVE_MIN:     drive_min_reg     <= cfg_data[DRIVE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the filtered incremental PI speed controller.
`timescale 1ns / 1ps

module testbench;
    import fips_pkg::*;

    // Fixed-point scale of the block at its default parameters.
    localparam int FRAC = 8;
    localparam longint ONE = longint'(1) << FRAC;

    // Register indexes past the end of the list; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Cycles without any handshake before the run is declared hung. The slowest
    // legal stretch is one beat of work, a receiver hold and a sender gap.
    localparam int WATCHDOG_LIMIT = 2000;
    // Settling time after the last result.
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_PHASES = 10;
    localparam int BEATS_PER_PHASE = 108;

    localparam logic [15:0] CORNERS [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;
    typedef enum logic {CHECK_PREDICT, CHECK_FIXED} check_t;
    typedef enum int {RX_STREAM, RX_COIN, RX_SLOW, RX_HOLD} rx_mode_t;

    // One row of the directed table: either a register write or an input beat.
    // Beat rows marked CHECK_FIXED carry a drive level that is evident by eye.
    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [15:0]            value;
        logic [15:0]            meas;
        logic [15:0]            targ;
        logic                   clr;
        check_t                 check;
        logic [DRIVE_W-1:0]     level;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [15:0]            measured_speed = '0;
    logic [15:0]            target_speed = '0;
    logic                   clear = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [DRIVE_W-1:0]     drive_level;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Shadow copy of the control registers, as the block should hold them.
    logic [GAIN_W-1:0]      kp_gain;
    logic [GAIN_W-1:0]      ki_gain;
    logic [WEIGHT_W-1:0]    lp_weight;
    logic [DRIVE_W-1:0]     drive_hi;
    logic [DRIVE_W-1:0]     drive_lo;

    // Shadow copy of the loop state: filtered speed, previous error, drive.
    logic signed [15:0]     est_speed;
    logic signed [17:0]     prior_error;
    logic [DRIVE_W-1:0]     drive_acc;

    // Drive levels owed by the block, oldest first.
    logic [DRIVE_W-1:0]     pending_drive [$];

    int mismatches = 0;
    int results_checked = 0;
    int beats_sent = 0;
    int clear_beats = 0;
    int reg_writes = 0;
    int burst_left = 0;
    int quiet_cycles = 0;
    int rx_tick = 0;
    rx_mode_t rx_mode = RX_STREAM;

    // Directed part. The opening beats run at the reset settings: an idle loop
    // sits at the lower limit, a full positive error drives to the upper limit
    // and a full negative swing back to the lower one. Then the limits are
    // crossed, the gains and weight are pushed to their tops, the weight is
    // written with bits above its width, and two writes land past the list.
    stim_row_t directed_rows [33] = '{
        '{ROW_ITEM, REG_PROP_GAIN,     16'h0000, 16'h0000, 16'h0000, 1'b0, CHECK_FIXED,   16'd1000},
        '{ROW_ITEM, REG_PROP_GAIN,     16'h0000, 16'h7FFF, 16'h7FFF, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_ITEM, REG_PROP_GAIN,     16'h0000, 16'h8000, 16'h8000, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_ITEM, REG_PROP_GAIN,     16'h0000, 16'h7FFF, 16'h8000, 1'b1, CHECK_FIXED,   16'd0},
        '{ROW_ITEM, REG_PROP_GAIN,     16'h0000, 16'h0000, 16'h7FFF, 1'b0, CHECK_FIXED,   16'd2200},
        '{ROW_ITEM, REG_PROP_GAIN,     16'h0000, 16'h0000, 16'h8000, 1'b0, CHECK_FIXED,   16'd1000},
        '{ROW_ITEM, REG_PROP_GAIN,     16'h0000, 16'h8000, 16'h7FFF, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_ITEM, REG_PROP_GAIN,     16'h0000, 16'h5555, 16'hAAAA, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_ITEM, REG_PROP_GAIN,     16'h0000, 16'hAAAA, 16'h5555, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_REG,  REG_DRIVE_MAX,     16'h0000, 16'h0000, 16'h0000, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_REG,  REG_DRIVE_MIN,     16'hFFFF, 16'h0000, 16'h0000, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_ITEM, REG_PROP_GAIN,     16'h0000, 16'h0064, 16'h00C8, 1'b0, CHECK_FIXED,   16'hFFFF},
        '{ROW_ITEM, REG_PROP_GAIN,     16'h0000, 16'h7FFF, 16'h8000, 1'b1, CHECK_FIXED,   16'd0},
        '{ROW_REG,  REG_PROP_GAIN,     16'hFFFF, 16'h0000, 16'h0000, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_REG,  REG_INTEG_GAIN,    16'hFFFF, 16'h0000, 16'h0000, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_REG,  REG_FILTER_WEIGHT, 16'h012C, 16'h0000, 16'h0000, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_REG,  REG_DRIVE_MAX,     16'hFFFF, 16'h0000, 16'h0000, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_REG,  REG_DRIVE_MIN,     16'h0000, 16'h0000, 16'h0000, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_ITEM, REG_PROP_GAIN,     16'h0000, 16'h03E8, 16'h03E8, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_ITEM, REG_PROP_GAIN,     16'h0000, 16'h7FFF, 16'h8000, 1'b0, CHECK_FIXED,   16'd0},
        '{ROW_ITEM, REG_PROP_GAIN,     16'h0000, 16'h8000, 16'h7FFF, 1'b0, CHECK_FIXED,   16'hFFFF},
        '{ROW_REG,  REG_FILTER_WEIGHT, 16'hFE00, 16'h0000, 16'h0000, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_ITEM, REG_PROP_GAIN,     16'h0000, 16'h7FFF, 16'h0064, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_ITEM, REG_PROP_GAIN,     16'h0000, 16'h8000, 16'hFF9C, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_REG,  REG_FILTER_WEIGHT, 16'h01FF, 16'h0000, 16'h0000, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_REG,  REG_SPARE_LO,      16'h0000, 16'h0000, 16'h0000, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_REG,  REG_SPARE_HI,      16'h0000, 16'h0000, 16'h0000, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_ITEM, REG_PROP_GAIN,     16'h0000, 16'h0100, 16'h0200, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_ITEM, REG_PROP_GAIN,     16'h0000, 16'hFFFF, 16'h0001, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_REG,  REG_PROP_GAIN,     16'h0000, 16'h0000, 16'h0000, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_REG,  REG_INTEG_GAIN,    16'h0000, 16'h0000, 16'h0000, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_ITEM, REG_PROP_GAIN,     16'h0000, 16'h1234, 16'h4321, 1'b0, CHECK_PREDICT, 16'd0},
        '{ROW_ITEM, REG_PROP_GAIN,     16'h0000, 16'h0000, 16'h0000, 1'b1, CHECK_FIXED,   16'd0}
    };

    filtered_incremental_pi_speed DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .measured_speed (measured_speed),
        .target_speed   (target_speed),
        .clear          (clear),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive_level    (drive_level),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #10 clk = ~clk;

    // Loop step for one accepted beat: low-pass the measurement, form the
    // error, add the incremental PI term to the drive and clamp it, the upper
    // limit first and the lower one last. All divisions truncate toward zero.
    function automatic logic [DRIVE_W-1:0] next_drive_level(logic [15:0] meas,
                                                            logic [15:0] targ,
                                                            logic clr);
        longint w;
        longint filt;
        longint err;
        longint bias;
        longint acc;
        if (clr) begin
            est_speed = '0;
            prior_error = '0;
            drive_acc = '0;
            return '0;
        end
        // A weight above one behaves as one.
        w = longint'(lp_weight);
        if (w > ONE)
            w = ONE;
        filt = ((ONE - w) * longint'(est_speed) + w * longint'($signed(meas))) / ONE;
        err = longint'($signed(targ)) - filt;
        bias = (longint'(kp_gain) * (err - longint'(prior_error))
                + longint'(ki_gain) * err) / ONE;
        acc = longint'(drive_acc) + bias;
        if (acc > longint'(drive_hi))
            acc = longint'(drive_hi);
        if (acc < longint'(drive_lo))
            acc = longint'(drive_lo);
        est_speed = filt[15:0];
        prior_error = err[17:0];
        drive_acc = acc[DRIVE_W-1:0];
        return drive_acc;
    endfunction

    function automatic logic [15:0] sat16(int v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    // Picks a gain that is often at one of its extremes.
    function automatic logic [15:0] pick_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 16'h0000;
        if (r < 30)
            return 16'hFFFF;
        return 16'($urandom_range(0, 2048));
    endfunction

    // Sends one input beat and books its expected drive level once the block
    // takes it. Afterwards the sender either goes on with its burst or pauses.
    task automatic send_item(logic [15:0] meas, logic [15:0] targ, logic clr,
                             check_t check, logic [DRIVE_W-1:0] level);
        logic [DRIVE_W-1:0] predicted;
        int gap;
        cfg_valid <= 1'b0;
        in_valid <= 1'b1;
        measured_speed <= meas;
        target_speed <= targ;
        clear <= clr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = next_drive_level(meas, targ, clr);
        pending_drive.push_back(check == CHECK_FIXED ? level : predicted);
        beats_sent++;
        if (clr)
            clear_beats++;
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            // A third of the bursts run straight into the next one.
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(0, 10);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Writes one register. The first write of a group waits until the block
    // has delivered every result and is ready for a new beat; further writes
    // in the same group follow back to back while the block stays idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        if (!cfg_valid) begin
            if (in_valid)
                in_valid <= 1'b0;
            burst_left = 0;
            // Checked between edges so the outcome does not hinge on which
            // process runs first at the edge.
            while (pending_drive.size() != 0 || !in_ready)
                @(negedge clk);
            @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        reg_writes++;
        case (idx)
            REG_PROP_GAIN:     kp_gain = value;
            REG_INTEG_GAIN:    ki_gain = value;
            REG_FILTER_WEIGHT: lp_weight = value[WEIGHT_W-1:0];
            REG_DRIVE_MAX:     drive_hi = value;
            REG_DRIVE_MIN:     drive_lo = value;
            default:           ;
        endcase
    endtask

    // Receiver: the ready pattern is drawn anew, at points set by rx_tick, from
    // streaming, coin flips, a slow trickle and a long hold.
    always @(posedge clk) begin
        if (rx_tick % 64 == 0)
            rx_mode = rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_STREAM: out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            RX_SLOW:   out_ready <= (rx_tick % 5 == 0);
            default:   out_ready <= (rx_tick % 64 >= 40);
        endcase
        rx_tick++;
    end

    // Output checker: every delivered beat must match the oldest expectation.
    always @(posedge clk) begin
        logic [DRIVE_W-1:0] want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_drive.size() == 0) begin
                $error("drive_level: no result expected, got %0d", drive_level);
                mismatches++;
            end
            else begin
                want = pending_drive.pop_front();
                results_checked++;
                if (drive_level !== want) begin
                    $error("drive_level: expected %0d, got %0d", want, drive_level);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a run that stops making handshakes is a hang.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("timeout: no handshake for %0d cycles, %0d results outstanding",
                   quiet_cycles, pending_drive.size());
            $display("status: fail");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] wt;
        logic [15:0] hi;
        logic [15:0] lo;
        logic [15:0] meas;
        logic [15:0] targ;
        logic clr;
        int set_point;
        int pick;
        int t;

        kp_gain = PROP_GAIN_RST;
        ki_gain = INTEG_GAIN_RST;
        lp_weight = FILTER_WEIGHT_RST;
        drive_hi = DRIVE_MAX_RST;
        drive_lo = DRIVE_MIN_RST;
        est_speed = '0;
        prior_error = '0;
        drive_acc = '0;
        set_point = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG)
                write_reg(directed_rows[i].idx, directed_rows[i].value);
            else
                send_item(directed_rows[i].meas, directed_rows[i].targ,
                          directed_rows[i].clr, directed_rows[i].check,
                          directed_rows[i].level);
        end

        // Random part: each phase loads a register setting, then runs a
        // closed-loop-like stream. Most beats sit near a slowly moving set
        // point so the drive wanders between the limits instead of pinning.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    kp = PROP_GAIN_RST;
                    ki = INTEG_GAIN_RST;
                    wt = 16'(FILTER_WEIGHT_RST);
                    hi = DRIVE_MAX_RST;
                    lo = DRIVE_MIN_RST;
                end
                1: begin
                    kp = 16'hFFFF;
                    ki = 16'hFFFF;
                    wt = 16'd256;
                    hi = 16'hFFFF;
                    lo = 16'h0000;
                end
                2: begin
                    kp = 16'h0000;
                    ki = 16'h0000;
                    wt = 16'h0000;
                    hi = 16'h0000;
                    lo = 16'h0000;
                end
                3: begin
                    kp = 16'd64;
                    ki = 16'd4;
                    wt = 16'd1;
                    hi = 16'd40000;
                    lo = 16'd100;
                end
                default: begin
                    kp = pick_gain();
                    ki = pick_gain();
                    // Now and then the upper bits of the weight are set too.
                    wt = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                     : 16'($urandom_range(0, 300));
                    hi = 16'($urandom_range(0, 65535));
                    lo = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                     : 16'($urandom_range(0, hi));
                end
            endcase
            write_reg(REG_PROP_GAIN, kp);
            write_reg(REG_INTEG_GAIN, ki);
            write_reg(REG_FILTER_WEIGHT, wt);
            write_reg(REG_DRIVE_MAX, hi);
            write_reg(REG_DRIVE_MIN, lo);

            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                if ($urandom_range(0, 39) == 0)
                    set_point = int'($urandom_range(0, 4000)) - 2000;
                pick = $urandom_range(0, 99);
                clr = 1'b0;
                if (pick < 4) begin
                    clr = 1'b1;
                    meas = 16'($urandom_range(0, 65535));
                    targ = 16'($urandom_range(0, 65535));
                end
                else if (pick < 62) begin
                    t = set_point + int'($urandom_range(0, 40)) - 20;
                    targ = sat16(t);
                    meas = sat16(t + int'($urandom_range(0, 100)) - 50);
                end
                else if (pick < 88) begin
                    meas = 16'($urandom_range(0, 65535));
                    targ = 16'($urandom_range(0, 65535));
                end
                else begin
                    meas = CORNERS[$urandom_range(0, 3)];
                    targ = CORNERS[$urandom_range(0, 3)];
                end
                send_item(meas, targ, clr, CHECK_PREDICT, '0);
            end
        end

        if (in_valid)
            in_valid <= 1'b0;
        while (pending_drive.size() != 0)
            @(negedge clk);
        // Any stray beat after the last expected one is caught by the checker.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input beats (%0d of them clears) and %0d register writes.",
                 beats_sent, clear_beats, reg_writes);
        $display("Compared %0d drive levels and found %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
design/fips_pkg.sv
design/fips_mac.sv
design/filtered_incremental_pi_speed.sv
sim/testbench.sv
